### rtl/vector_distance_dot_unit_defines.svh
// Assertion macros used by the checker file of the vector distance and dot product unit.
`ifndef VECTOR_DISTANCE_DOT_UNIT_DEFINES_SVH
`define VECTOR_DISTANCE_DOT_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VDD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define VDD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/vdd_pkg.sv
// Package with the types, constants and control structs of the vector distance and dot unit.
package vdd_pkg;

  localparam int COMPONENT_WIDTH = 32;
  localparam int COMP_PORT_W     = 32;
  localparam int VALUE_W         = 64;
  localparam int MODE_W          = 3;
  localparam int SQRT_STEPS      = VALUE_W / 2;
  localparam int SQRT_CNT_W      = $clog2(SQRT_STEPS);

  localparam logic [VALUE_W-1:0] SQRT_TOP_BIT = {2'b01, {(VALUE_W-2){1'b0}}};

  typedef logic [MODE_W-1:0] mode_t;

  localparam mode_t MODE_ADD   = 3'd0;
  localparam mode_t MODE_SUB   = 3'd1;
  localparam mode_t MODE_DOT   = 3'd2;
  localparam mode_t MODE_DIST  = 3'd3;
  localparam mode_t MODE_EQ    = 3'd4;
  localparam mode_t MODE_RESET = MODE_DIST;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OPER,
    ST_MUL,
    ST_ACC,
    ST_SQINIT,
    ST_SQRT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic oper;
    logic mul;
    logic acc;
    logic sq_init;
    logic sq_step;
    logic emit;
    logic clear;
  } cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  last;
  } status_t;

endpackage

### rtl/vdd_if.sv
// Channel interfaces for the input, result and configuration transactions.
interface vdd_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [vdd_pkg::COMP_PORT_W-1:0] component_a;
  logic signed [vdd_pkg::COMP_PORT_W-1:0] component_b;
  logic                                   last_element;

  modport source (output valid, output component_a, output component_b,
                  output last_element, input ready);
  modport sink (input valid, input component_a, input component_b,
                input last_element, output ready);
endinterface

interface vdd_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [vdd_pkg::VALUE_W-1:0] value;
  logic                               is_equal;
  logic                               overflow;
  logic                               last_result;

  modport source (output valid, output value, output is_equal, output overflow,
                  output last_result, input ready);
  modport sink (input valid, input value, input is_equal, input overflow,
                input last_result, output ready);
endinterface

interface vdd_cfg_if;
  logic                 valid;
  logic                 ready;
  logic [vdd_pkg::MODE_W-1:0] mode;

  modport source (output valid, output mode, input ready);
  modport sink (input valid, input mode, output ready);
endinterface

### rtl/vdd_ctrl.sv
// Controller state machine that sequences each transaction through the datapath.
module vdd_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  vdd_pkg::status_t status,
  output vdd_pkg::cmd_t    cmd
);

  vdd_pkg::state_t                 state_r, state_nxt;
  logic [vdd_pkg::SQRT_CNT_W-1:0]  sq_cnt_r, sq_cnt_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic                            out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vdd_pkg::ST_IDLE;
      sq_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sq_cnt_r    <= sq_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    sq_cnt_nxt    = sq_cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    cmd           = '0;
    case (state_r)
      vdd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = vdd_pkg::ST_OPER;
        end
      end
      vdd_pkg::ST_OPER: begin
        cmd.oper = 1'b1;
        case (status.mode)
          vdd_pkg::MODE_ADD, vdd_pkg::MODE_SUB: begin
            state_nxt = vdd_pkg::ST_EMIT;
          end
          vdd_pkg::MODE_DOT, vdd_pkg::MODE_DIST: begin
            state_nxt = vdd_pkg::ST_MUL;
          end
          vdd_pkg::MODE_EQ: begin
            state_nxt = status.last ? vdd_pkg::ST_EMIT : vdd_pkg::ST_IDLE;
          end
          default: begin
            cmd.clear = status.last;
            state_nxt = vdd_pkg::ST_IDLE;
          end
        endcase
      end
      vdd_pkg::ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = vdd_pkg::ST_ACC;
      end
      vdd_pkg::ST_ACC: begin
        cmd.acc = 1'b1;
        if (!status.last) begin
          state_nxt = vdd_pkg::ST_IDLE;
        end else if (status.mode == vdd_pkg::MODE_DIST) begin
          state_nxt = vdd_pkg::ST_SQINIT;
        end else begin
          state_nxt = vdd_pkg::ST_EMIT;
        end
      end
      vdd_pkg::ST_SQINIT: begin
        cmd.sq_init = 1'b1;
        sq_cnt_nxt  = '0;
        state_nxt   = vdd_pkg::ST_SQRT;
      end
      vdd_pkg::ST_SQRT: begin
        cmd.sq_step = 1'b1;
        sq_cnt_nxt  = sq_cnt_r + 1'b1;
        if (sq_cnt_r == vdd_pkg::SQRT_CNT_W'(vdd_pkg::SQRT_STEPS - 1)) begin
          state_nxt = vdd_pkg::ST_EMIT;
        end
      end
      vdd_pkg::ST_EMIT: begin
        if (out_free) begin
          cmd.emit      = 1'b1;
          cmd.clear     = status.last;
          out_valid_nxt = 1'b1;
          state_nxt     = vdd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = vdd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/vdd_datapath.sv
// Datapath with operand stage, multiplier, saturating accumulator, square root and result register.
module vdd_datapath #(
  parameter int COMPONENT_WIDTH = vdd_pkg::COMPONENT_WIDTH
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  vdd_pkg::cmd_t                          cmd,
  output vdd_pkg::status_t                       status,
  input  logic                                   cfg_write,
  input  vdd_pkg::mode_t                         cfg_mode,
  input  logic signed [vdd_pkg::COMP_PORT_W-1:0] component_a,
  input  logic signed [vdd_pkg::COMP_PORT_W-1:0] component_b,
  input  logic                                   last_element,
  output logic signed [vdd_pkg::VALUE_W-1:0]     value,
  output logic                                   is_equal,
  output logic                                   overflow,
  output logic                                   last_result
);

  localparam int CW = COMPONENT_WIDTH;
  localparam int VW = vdd_pkg::VALUE_W;
  localparam int PW = (2 * CW + 2 > VW) ? 2 * CW + 2 : VW;

  vdd_pkg::mode_t          mode_r;
  logic signed [CW-1:0]    a_r, b_r;
  logic                    last_r;
  logic signed [CW-1:0]    addsub_r;
  logic                    addsub_ov_r;
  logic signed [CW:0]      mul_x_r, mul_y_r;
  logic signed [VW-1:0]    prod_r;
  logic [VW-1:0]           acc_r;
  logic                    all_equal_r;
  logic                    sticky_r;
  logic [VW-1:0]           sq_n_r, sq_res_r, sq_bit_r;
  logic signed [VW-1:0]    value_r;
  logic                    is_equal_r, overflow_r, last_result_r;

  logic signed [CW:0]      a_ext, b_ext, sum, diff, mag;
  logic                    sum_ov;
  logic signed [CW-1:0]    sum_sat;
  logic signed [2*CW+1:0]  prod_full;
  logic signed [PW-1:0]    prod_ext;
  logic                    acc_signed;
  logic [VW:0]             acc_sum;
  logic                    acc_ov;
  logic [VW-1:0]           acc_sat;
  logic [VW-1:0]           sq_try;
  logic                    sq_fit;

  assign status.mode = mode_r;
  assign status.last = last_r;

  assign a_ext   = (CW+1)'(a_r);
  assign b_ext   = (CW+1)'(b_r);
  assign sum     = (mode_r == vdd_pkg::MODE_SUB) ? a_ext - b_ext : a_ext + b_ext;
  assign sum_ov  = sum[CW] != sum[CW-1];
  assign sum_sat = sum[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
  assign diff    = a_ext - b_ext;
  assign mag     = diff[CW] ? -diff : diff;

  assign prod_full = mul_x_r * mul_y_r;
  assign prod_ext  = PW'(prod_full);

  assign acc_signed = mode_r == vdd_pkg::MODE_DOT;
  assign acc_sum    = {acc_signed & acc_r[VW-1], acc_r} + {acc_signed & prod_r[VW-1], prod_r};
  assign acc_ov     = acc_signed ? (acc_sum[VW] != acc_sum[VW-1]) : acc_sum[VW];
  assign acc_sat    = !acc_signed ? {VW{1'b1}} :
                      prod_r[VW-1] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};

  assign sq_try = sq_res_r + sq_bit_r;
  assign sq_fit = sq_n_r >= sq_try;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= vdd_pkg::MODE_RESET;
    end else if (cfg_write) begin
      mode_r <= cfg_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      all_equal_r <= 1'b1;
      sticky_r    <= 1'b0;
    end else if (cmd.clear) begin
      acc_r       <= '0;
      all_equal_r <= 1'b1;
      sticky_r    <= 1'b0;
    end else begin
      if (cmd.oper && mode_r == vdd_pkg::MODE_EQ && a_r != b_r) begin
        all_equal_r <= 1'b0;
      end
      if (cmd.acc) begin
        if (acc_ov) begin
          acc_r    <= acc_sat;
          sticky_r <= 1'b1;
        end else begin
          acc_r <= acc_sum[VW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_r    <= component_a[CW-1:0];
      b_r    <= component_b[CW-1:0];
      last_r <= last_element;
    end
    if (cmd.oper) begin
      addsub_r    <= sum_ov ? sum_sat : sum[CW-1:0];
      addsub_ov_r <= sum_ov;
      if (mode_r == vdd_pkg::MODE_DOT) begin
        mul_x_r <= a_ext;
        mul_y_r <= b_ext;
      end else begin
        mul_x_r <= mag;
        mul_y_r <= mag;
      end
    end
    if (cmd.mul) begin
      prod_r <= prod_ext[VW-1:0];
    end
    if (cmd.sq_init) begin
      sq_n_r   <= acc_r;
      sq_res_r <= '0;
      sq_bit_r <= vdd_pkg::SQRT_TOP_BIT;
    end else if (cmd.sq_step) begin
      if (sq_fit) begin
        sq_n_r   <= sq_n_r - sq_try;
        sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
      end else begin
        sq_res_r <= sq_res_r >> 1;
      end
      sq_bit_r <= sq_bit_r >> 2;
    end
    if (cmd.emit) begin
      last_result_r <= last_r;
      case (mode_r)
        vdd_pkg::MODE_ADD, vdd_pkg::MODE_SUB: begin
          value_r    <= VW'(addsub_r);
          is_equal_r <= 1'b0;
          overflow_r <= addsub_ov_r;
        end
        vdd_pkg::MODE_DOT: begin
          value_r    <= acc_r;
          is_equal_r <= 1'b0;
          overflow_r <= sticky_r;
        end
        vdd_pkg::MODE_DIST: begin
          value_r    <= sq_res_r;
          is_equal_r <= 1'b0;
          overflow_r <= sticky_r;
        end
        default: begin
          value_r    <= '0;
          is_equal_r <= all_equal_r;
          overflow_r <= 1'b0;
        end
      endcase
    end
  end

  assign value       = value_r;
  assign is_equal    = is_equal_r;
  assign overflow    = overflow_r;
  assign last_result = last_result_r;

endmodule

### rtl/vector_distance_dot_unit.sv
// Top level of the vector distance and dot product unit.
//
//   channel    direction  transaction payload
//   cfg_chan   in         mode
//   in_chan    in         component_a, component_b, last_element
//   out_chan   out        value, is_equal, overflow, last_result
//
// Add and subtract pass each pair through load, operand and emit; equality and the unused
// modes through load and operand, and the last pair of an equality test also emits. Dot
// product and distance add multiply and accumulate; their last pair also emits, a distance
// after a one-bit-per-cycle square root over the 64-bit accumulator. One pair at a time.
// Reset (synchronous, active low) sets mode to distance and clears the accumulator.
// A waiting result holds the unit only when the next result is ready to be written.
module vector_distance_dot_unit #(
  parameter int COMPONENT_WIDTH = vdd_pkg::COMPONENT_WIDTH
) (
  input  logic          clk,
  input  logic          rst_n,
  vdd_cfg_if.sink       cfg_chan,
  vdd_in_if.sink        in_chan,
  vdd_out_if.source     out_chan
);

  vdd_pkg::cmd_t    cmd;
  vdd_pkg::status_t status;

  assign cfg_chan.ready = 1'b1;

  vdd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .status    (status),
    .cmd       (cmd)
  );

  vdd_datapath #(
    .COMPONENT_WIDTH (COMPONENT_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .cfg_write    (cfg_chan.valid),
    .cfg_mode     (cfg_chan.mode),
    .component_a  (in_chan.component_a),
    .component_b  (in_chan.component_b),
    .last_element (in_chan.last_element),
    .value        (out_chan.value),
    .is_equal     (out_chan.is_equal),
    .overflow     (out_chan.overflow),
    .last_result  (out_chan.last_result)
  );

endmodule

### rtl/vdd_checker.sv
// Port-level assertion checker for the vector distance and dot product unit, with its bind.
`include "vector_distance_dot_unit_defines.svh"

module vdd_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [vdd_pkg::VALUE_W-1:0] value,
  input logic                               is_equal,
  input logic                               overflow,
  input logic                               last_result
);

  `VDD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(value) && $stable(is_equal) && $stable(overflow) && $stable(last_result), "result changed while stalled")
  `VDD_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "input accepted while a transaction is in progress")
  `VDD_ASSERT_NEXT(a_no_instant_result, in_valid && in_ready, !$rose(out_valid), "result appeared one cycle after its transaction")
  `VDD_ASSERT_SAME(a_equal_shape, out_valid && is_equal, last_result && value == 0 && !overflow, "equality result malformed")

endmodule

bind vector_distance_dot_unit vdd_checker u_vdd_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_chan.valid),
  .in_ready    (in_chan.ready),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .value       (out_chan.value),
  .is_equal    (out_chan.is_equal),
  .overflow    (out_chan.overflow),
  .last_result (out_chan.last_result)
);

### dv/vector_distance_dot_unit_test.sv
// Self-checking testbench for the vector distance and dot product unit.
`timescale 1ns / 1ps

module vector_distance_dot_unit_test;

  localparam int SETTLE_CYCLES = 50;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_ITEMS  = 800;

  localparam logic signed [31:0] COMP_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] COMP_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] Q_ONE    = 32'sh0001_0000;

  localparam vdd_pkg::mode_t MODE_UNUSED_LO  = 3'd5;
  localparam vdd_pkg::mode_t MODE_UNUSED_MID = 3'd6;
  localparam vdd_pkg::mode_t MODE_UNUSED_HI  = 3'd7;

  typedef struct packed {
    logic [63:0] value;
    logic        is_equal;
    logic        overflow;
    logic        last_result;
  } vector_result_t;

  logic clk = 1'b0;
  logic rst_n;

  vdd_cfg_if cfg_chan ();
  vdd_in_if  in_chan ();
  vdd_out_if out_chan ();

  vector_distance_dot_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  vdd_pkg::mode_t pred_mode;
  logic [63:0]    run_sum;
  logic           all_match;
  logic           sum_saturated;
  vector_result_t expected_results[$];

  int fail_count;
  int tx_idle_pct;
  int rx_stall_pct;
  int hold_request;
  int hold_len;
  bit rx_hold;
  int items_sent;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #1_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [63:0] floor_root(input logic [63:0] n);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int i = 31; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (trial * trial <= n) begin
        root = trial;
      end
    end
    return root;
  endfunction

  function automatic bit predict_pair_result(input logic signed [31:0] a,
                                             input logic signed [31:0] b,
                                             input logic last,
                                             output vector_result_t r);
    logic signed [32:0] sum;
    logic signed [63:0] prod;
    logic signed [63:0] acc_s;
    logic signed [64:0] dot_sum;
    logic signed [32:0] diff;
    logic [63:0]        mag;
    logic [63:0]        sq;
    logic [64:0]        dist_sum;
    bit                 has_result;
    r = '0;
    r.last_result = last;
    has_result = 1'b0;
    case (pred_mode)
      vdd_pkg::MODE_ADD, vdd_pkg::MODE_SUB: begin
        sum = a;
        if (pred_mode == vdd_pkg::MODE_ADD) begin
          sum = sum + b;
        end else begin
          sum = sum - b;
        end
        if (sum[32] != sum[31]) begin
          r.value = sum[32] ? {{32{1'b1}}, COMP_MIN} : {32'd0, COMP_MAX};
          r.overflow = 1'b1;
        end else begin
          r.value = {{32{sum[31]}}, sum[31:0]};
        end
        has_result = 1'b1;
      end
      vdd_pkg::MODE_DOT: begin
        prod = a * b;
        acc_s = run_sum;
        dot_sum = acc_s + prod;
        if (dot_sum[64] != dot_sum[63]) begin
          run_sum = dot_sum[64] ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
          sum_saturated = 1'b1;
        end else begin
          run_sum = dot_sum[63:0];
        end
        if (last) begin
          r.value = run_sum;
          r.overflow = sum_saturated;
          has_result = 1'b1;
        end
      end
      vdd_pkg::MODE_DIST: begin
        diff = a;
        diff = diff - b;
        mag = diff[32] ? 64'(-diff) : 64'(diff);
        mag = mag & 64'h1_ffff_ffff;
        sq = mag * mag;
        dist_sum = {1'b0, run_sum} + {1'b0, sq};
        if (dist_sum[64]) begin
          run_sum = '1;
          sum_saturated = 1'b1;
        end else begin
          run_sum = dist_sum[63:0];
        end
        if (last) begin
          r.value = floor_root(run_sum);
          r.overflow = sum_saturated;
          has_result = 1'b1;
        end
      end
      vdd_pkg::MODE_EQ: begin
        if (a != b) begin
          all_match = 1'b0;
        end
        if (last) begin
          r.is_equal = all_match;
          has_result = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (last) begin
      run_sum = '0;
      all_match = 1'b1;
      sum_saturated = 1'b0;
    end
    return has_result;
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t: %s", $realtime, msg);
    end
  endtask

  always @(posedge clk) begin
    vector_result_t predicted;
    vector_result_t seen;
    if (!rst_n) begin
      pred_mode = vdd_pkg::MODE_RESET;
      run_sum = '0;
      all_match = 1'b1;
      sum_saturated = 1'b0;
    end else begin
      if (cfg_chan.valid && cfg_chan.ready) begin
        pred_mode = cfg_chan.mode;
      end
      if (in_chan.valid && in_chan.ready) begin
        if (predict_pair_result(in_chan.component_a, in_chan.component_b,
                                in_chan.last_element, predicted)) begin
          expected_results.push_back(predicted);
        end
      end
      if (out_chan.valid && out_chan.ready) begin
        seen = '{value: out_chan.value, is_equal: out_chan.is_equal,
                 overflow: out_chan.overflow, last_result: out_chan.last_result};
        if (expected_results.size() == 0) begin
          note_failure($sformatf("unexpected result transaction value %h", seen.value));
        end else begin
          predicted = expected_results.pop_front();
          if (seen != predicted) begin
            note_failure($sformatf(
              "result mismatch: expected value %h eq %b ov %b last %b, got %h %b %b %b",
              predicted.value, predicted.is_equal, predicted.overflow,
              predicted.last_result, seen.value, seen.is_equal, seen.overflow,
              seen.last_result));
          end
        end
      end
    end
  end

  always begin
    @(posedge clk);
    if (hold_request > 0) begin
      hold_len = hold_request;
      hold_request = 0;
      rx_hold <= 1'b1;
      repeat (hold_len) @(posedge clk);
      rx_hold <= 1'b0;
    end
  end

  always @(posedge clk) begin
    out_chan.ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
  end

  task automatic send_pair(input logic signed [31:0] a, input logic signed [31:0] b,
                           input logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid        <= 1'b1;
    in_chan.component_a  <= a;
    in_chan.component_b  <= b;
    in_chan.last_element <= last;
    do @(posedge clk); while (!in_chan.ready);
    items_sent++;
  endtask

  task automatic wait_results_drained();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_mode(input vdd_pkg::mode_t m);
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_chan.valid <= 1'b1;
    cfg_chan.mode  <= m;
    do @(posedge clk); while (!cfg_chan.ready);
    cfg_chan.valid <= 1'b0;
  endtask

  function automatic logic signed [31:0] pick_component();
    case ($urandom_range(7))
      0: return COMP_MIN;
      1: return COMP_MAX;
      2, 3: return 32'($urandom_range(262143)) - 32'sd131072;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random_vector(input int len, input bit close_vector);
    logic signed [31:0] a;
    logic signed [31:0] b;
    bit                 matched;
    matched = $urandom_range(1);
    for (int i = 0; i < len; i++) begin
      a = pick_component();
      b = (matched && $urandom_range(9) != 0) ? a : pick_component();
      send_pair(a, b, close_vector && (i == len - 1));
    end
  endtask

  task automatic test_reset_distance();
    send_pair(COMP_MIN, COMP_MAX, 1'b1);
    send_pair(Q_ONE, Q_ONE, 1'b1);
    send_pair(32'sd0, -Q_ONE * 3, 1'b0);
    send_pair(4 * Q_ONE, 32'sd0, 1'b1);
    send_pair(COMP_MAX, COMP_MIN, 1'b0);
    send_pair(COMP_MIN, COMP_MAX, 1'b1);
  endtask

  task automatic test_add_sub();
    write_mode(vdd_pkg::MODE_ADD);
    send_pair(COMP_MAX, COMP_MAX, 1'b0);
    send_pair(COMP_MIN, COMP_MIN, 1'b1);
    send_pair(COMP_MIN, COMP_MAX, 1'b0);
    write_mode(vdd_pkg::MODE_SUB);
    send_pair(COMP_MIN, Q_ONE, 1'b0);
    send_pair(32'sd0, COMP_MIN, 1'b1);
    send_pair(COMP_MAX, -32'sd1, 1'b0);
  endtask

  task automatic test_dot_product();
    write_mode(vdd_pkg::MODE_DOT);
    send_pair(COMP_MIN, COMP_MIN, 1'b0);
    send_pair(COMP_MIN, COMP_MIN, 1'b1);
    send_pair(COMP_MIN, COMP_MAX, 1'b0);
    send_pair(COMP_MIN, COMP_MAX, 1'b0);
    send_pair(COMP_MIN, COMP_MAX, 1'b1);
    send_pair(2 * Q_ONE, -Q_ONE, 1'b1);
  endtask

  task automatic test_equality();
    write_mode(vdd_pkg::MODE_EQ);
    send_pair(COMP_MAX, COMP_MAX, 1'b0);
    send_pair(COMP_MIN, COMP_MIN, 1'b1);
    send_pair(Q_ONE, Q_ONE, 1'b0);
    send_pair(Q_ONE, Q_ONE + 1, 1'b1);
  endtask

  task automatic test_unused_modes();
    write_mode(MODE_UNUSED_LO);
    send_pair(Q_ONE, Q_ONE, 1'b0);
    write_mode(MODE_UNUSED_MID);
    send_pair(COMP_MAX, COMP_MIN, 1'b1);
    write_mode(MODE_UNUSED_HI);
    send_pair(COMP_MIN, 32'sd0, 1'b1);
  endtask

  task automatic test_mode_switch_mid_vector();
    write_mode(vdd_pkg::MODE_DOT);
    send_pair(COMP_MIN, COMP_MAX, 1'b0);
    write_mode(vdd_pkg::MODE_DIST);
    send_pair(Q_ONE, 32'sd0, 1'b1);
    write_mode(vdd_pkg::MODE_DIST);
    send_pair(COMP_MAX, COMP_MIN, 1'b0);
    write_mode(vdd_pkg::MODE_DOT);
    send_pair(Q_ONE, Q_ONE, 1'b1);
    write_mode(vdd_pkg::MODE_EQ);
    send_pair(Q_ONE, 32'sd0, 1'b0);
    write_mode(vdd_pkg::MODE_ADD);
    send_pair(Q_ONE, Q_ONE, 1'b0);
    write_mode(vdd_pkg::MODE_EQ);
    send_pair(Q_ONE, Q_ONE, 1'b1);
  endtask

  task automatic test_output_backpressure();
    write_mode(vdd_pkg::MODE_ADD);
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_request = HOLD_CYCLES;
    for (int i = 0; i < 40; i++) begin
      send_pair(pick_component(), pick_component(), $urandom_range(1));
    end
    wait_results_drained();
  endtask

  task automatic test_random_vectors(input int tx_pct, input int rx_pct, input int item_goal);
    int             stop_at;
    int             segment_end;
    vdd_pkg::mode_t m;
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    stop_at = items_sent + item_goal;
    while (items_sent < stop_at) begin
      m = ($urandom_range(9) == 0) ? vdd_pkg::mode_t'($urandom_range(7))
                                   : vdd_pkg::mode_t'($urandom_range(4));
      write_mode(m);
      segment_end = items_sent + $urandom_range(20, 60);
      while (items_sent < segment_end) begin
        send_random_vector(($urandom_range(9) == 0) ? $urandom_range(8, 20)
                                                     : $urandom_range(1, 6),
                           $urandom_range(9) != 0);
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_chan.valid = 1'b0;
    cfg_chan.mode = vdd_pkg::MODE_RESET;
    in_chan.valid = 1'b0;
    in_chan.component_a = '0;
    in_chan.component_b = '0;
    in_chan.last_element = 1'b0;
    out_chan.ready = 1'b0;
    fail_count = 0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_request = 0;
    rx_hold = 1'b0;
    items_sent = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_distance();
    test_add_sub();
    test_dot_product();
    test_equality();
    test_unused_modes();
    test_mode_switch_mid_vector();
    test_output_backpressure();
    test_random_vectors(0, 0, RANDOM_ITEMS / 4);
    test_random_vectors(70, 0, RANDOM_ITEMS / 4);
    test_random_vectors(0, 70, RANDOM_ITEMS / 4);
    test_random_vectors(24, 24, RANDOM_ITEMS / 4);

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/vdd_pkg.sv
rtl/vdd_if.sv
rtl/vdd_ctrl.sv
rtl/vdd_datapath.sv
rtl/vector_distance_dot_unit.sv
rtl/vdd_checker.sv
dv/vector_distance_dot_unit_test.sv
